@@ rtl/token_bucket_policer_assert.svh @@
// ---------------------------------------------------------------------------
// Token bucket policer assertion macros
// Shorthand for the concurrent checks on the policer's ports.
// ---------------------------------------------------------------------------
`ifndef TOKEN_BUCKET_POLICER_ASSERT_SVH
`define TOKEN_BUCKET_POLICER_ASSERT_SVH

// Check on every clock edge outside reset.
`define TBP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define TBP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/tbp_pkg.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer package
// Widths, reset values, codes and pipeline item types shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package tbp_pkg;

  localparam int FRACTION_BITS_DEF = 24;
  localparam int COUNTER_BITS_DEF  = 48;

  localparam int LEN_W       = 16;
  localparam int TIME_W      = 64;
  localparam int CFG_W       = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int ELAPSED_W   = 32;
  localparam int PROD_W      = 64;
  localparam int TOKENS_W    = 32;
  localparam int OUT_CNT_W   = 48;
  localparam int VERDICT_W   = 2;

  localparam logic [CFG_W-1:0] RATE_RESET = 32'd20971520;
  localparam logic [CFG_W-1:0] SIZE_RESET = 32'd65536;

  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_PASS    = 2'd0,
    VERDICT_DROP    = 2'd1,
    VERDICT_INVALID = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FILL_RATE   = 1'b0,
    CFG_BUCKET_SIZE = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    REFILL_NONE = 2'd0,
    REFILL_ADD  = 2'd1,
    REFILL_FULL = 2'd2
  } refill_t;

  typedef struct packed {
    logic [LEN_W-1:0]     len;
    refill_t              mode;
    logic [ELAPSED_W-1:0] elapsed;
  } elapsed_item_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    refill_t           mode;
    logic [PROD_W-1:0] added;
  } refill_item_t;

  typedef struct packed {
    logic             restart;
    logic [CFG_W-1:0] size;
  } restart_t;

endpackage

`default_nettype wire

@@ rtl/tbp_front.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer front end
// Input register, elapsed time against the stored timestamp, refill mode.
// ---------------------------------------------------------------------------
`default_nettype none

module tbp_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tbp_pkg::restart_t            restart,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tbp_pkg::LEN_W-1:0]    in_packet_length,
  input  logic [tbp_pkg::TIME_W-1:0]   in_arrival_time,
  output logic                         item_valid,
  output tbp_pkg::elapsed_item_t       item,
  input  logic                         item_ready
);
  import tbp_pkg::*;

  logic               s1_valid_r;
  logic [LEN_W-1:0]   s1_len_r;
  logic [TIME_W-1:0]  s1_time_r;
  logic [TIME_W-1:0]  last_time_r;
  logic [TIME_W-1:0]  last_time_nxt;
  logic               item_valid_r;
  elapsed_item_t      item_r;
  elapsed_item_t      item_nxt;
  logic               s1_ready;
  logic               s2_ready;
  logic               s1_move;
  logic [TIME_W-1:0]  diff;

  assign s2_ready = !item_valid_r || item_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign s1_move  = s1_valid_r && s2_ready;
  assign in_stall = !s1_ready;

  always_comb begin
    diff             = s1_time_r - last_time_r;
    item_nxt.len     = s1_len_r;
    item_nxt.elapsed = diff[ELAPSED_W-1:0];
    if (s1_len_r == '0 || s1_time_r < last_time_r) begin
      item_nxt.mode = REFILL_NONE;
    end else if (diff[TIME_W-1:ELAPSED_W] != '0) begin
      item_nxt.mode = REFILL_FULL;
    end else begin
      item_nxt.mode = REFILL_ADD;
    end

    // advance the stored time only for a valid packet that is not older
    last_time_nxt = last_time_r;
    if (restart.restart) begin
      last_time_nxt = '0;
    end else if (s1_move && item_nxt.mode != REFILL_NONE) begin
      last_time_nxt = s1_time_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      item_valid_r <= 1'b0;
      last_time_r  <= '0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        item_valid_r <= s1_valid_r;
      end
      last_time_r <= last_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && s1_ready) begin
      s1_len_r  <= in_packet_length;
      s1_time_r <= in_arrival_time;
    end
    if (s1_move) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = item_valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

@@ rtl/tbp_refill_mul.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer refill multiplier
// Registered product of elapsed time and fill rate.
// ---------------------------------------------------------------------------
`default_nettype none

module tbp_refill_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [tbp_pkg::CFG_W-1:0]   fill_rate,
  input  logic                        in_item_valid,
  input  tbp_pkg::elapsed_item_t      in_item,
  output logic                        in_item_ready,
  output logic                        out_item_valid,
  output tbp_pkg::refill_item_t       out_item,
  input  logic                        out_item_ready
);
  import tbp_pkg::*;

  logic          valid_r;
  refill_item_t  item_r;
  refill_item_t  item_nxt;
  logic          ready;

  assign ready         = !valid_r || out_item_ready;
  assign in_item_ready = ready;

  always_comb begin
    item_nxt.len   = in_item.len;
    item_nxt.mode  = in_item.mode;
    item_nxt.added = PROD_W'(in_item.elapsed) * PROD_W'(fill_rate);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready) begin
      valid_r <= in_item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && in_item_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_item_valid = valid_r;
  assign out_item       = item_r;

endmodule

`default_nettype wire

@@ rtl/tbp_bucket.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer bucket
// Level refill and cap, pass or drop decision, counters and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tbp_bucket #(
  parameter int FRACTION_BITS = tbp_pkg::FRACTION_BITS_DEF,
  parameter int COUNTER_BITS  = tbp_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  tbp_pkg::restart_t              restart,
  input  logic [tbp_pkg::CFG_W-1:0]      bucket_size,
  input  logic                           in_item_valid,
  input  tbp_pkg::refill_item_t          in_item,
  output logic                           in_item_ready,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tbp_pkg::VERDICT_W-1:0]  out_verdict,
  output logic [tbp_pkg::TOKENS_W-1:0]   out_tokens_left,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_packets,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_bytes,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_packets,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_bytes
);
  import tbp_pkg::*;

  localparam int LVL_W = CFG_W + FRACTION_BITS;
  localparam int SUM_W = PROD_W + 1;

  logic [LVL_W-1:0]        level_r, level_nxt;
  logic [COUNTER_BITS-1:0] pass_pkts_r, pass_pkts_nxt;
  logic [COUNTER_BITS-1:0] pass_bytes_r, pass_bytes_nxt;
  logic [COUNTER_BITS-1:0] drop_pkts_r, drop_pkts_nxt;
  logic [COUNTER_BITS-1:0] drop_bytes_r, drop_bytes_nxt;
  logic                    out_valid_r, out_valid_nxt;
  verdict_t                verdict_r, verdict_nxt;
  logic                    ready;
  logic                    take;
  logic [LVL_W-1:0]        cap;
  logic [SUM_W-1:0]        sum;
  logic [LVL_W-1:0]        refilled;
  logic [LVL_W-1:0]        need;

  assign ready         = !out_valid_r || !out_stall;
  assign take          = ready && in_item_valid;
  assign in_item_ready = ready;

  always_comb begin
    cap  = LVL_W'(bucket_size) << FRACTION_BITS;
    sum  = SUM_W'(level_r) + SUM_W'(in_item.added);
    need = LVL_W'(in_item.len) << FRACTION_BITS;

    case (in_item.mode)
      REFILL_NONE: refilled = level_r;
      REFILL_ADD:  refilled = (sum >= SUM_W'(cap)) ? cap : sum[LVL_W-1:0];
      REFILL_FULL: refilled = cap;
      default:     refilled = level_r;
    endcase

    level_nxt      = level_r;
    pass_pkts_nxt  = pass_pkts_r;
    pass_bytes_nxt = pass_bytes_r;
    drop_pkts_nxt  = drop_pkts_r;
    drop_bytes_nxt = drop_bytes_r;
    verdict_nxt    = verdict_r;
    out_valid_nxt  = out_valid_r && out_stall;

    if (restart.restart) begin
      level_nxt      = LVL_W'(restart.size) << FRACTION_BITS;
      pass_pkts_nxt  = '0;
      pass_bytes_nxt = '0;
      drop_pkts_nxt  = '0;
      drop_bytes_nxt = '0;
    end else if (take) begin
      out_valid_nxt = 1'b1;
      if (in_item.len == '0) begin
        verdict_nxt = VERDICT_INVALID;
      end else if (refilled >= need) begin
        verdict_nxt    = VERDICT_PASS;
        level_nxt      = refilled - need;
        pass_pkts_nxt  = pass_pkts_r + COUNTER_BITS'(1);
        pass_bytes_nxt = pass_bytes_r + COUNTER_BITS'(in_item.len);
      end else begin
        verdict_nxt    = VERDICT_DROP;
        level_nxt      = refilled;
        drop_pkts_nxt  = drop_pkts_r + COUNTER_BITS'(1);
        drop_bytes_nxt = drop_bytes_r + COUNTER_BITS'(in_item.len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      level_r      <= LVL_W'(SIZE_RESET) << FRACTION_BITS;
      pass_pkts_r  <= '0;
      pass_bytes_r <= '0;
      drop_pkts_r  <= '0;
      drop_bytes_r <= '0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      level_r      <= level_nxt;
      pass_pkts_r  <= pass_pkts_nxt;
      pass_bytes_r <= pass_bytes_nxt;
      drop_pkts_r  <= drop_pkts_nxt;
      drop_bytes_r <= drop_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
  end

  // the state registers double as the result fields
  assign out_valid           = out_valid_r;
  assign out_verdict         = verdict_r;
  assign out_tokens_left     = level_r[FRACTION_BITS +: TOKENS_W];
  assign out_passed_packets  = OUT_CNT_W'(pass_pkts_r);
  assign out_passed_bytes    = OUT_CNT_W'(pass_bytes_r);
  assign out_dropped_packets = OUT_CNT_W'(drop_pkts_r);
  assign out_dropped_bytes   = OUT_CNT_W'(drop_bytes_r);

endmodule

`default_nettype wire

@@ rtl/token_bucket_policer.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer
// Single-rate policer: one verdict and the running counters per packet.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: in_valid / in_stall carries one packet item (length in
//   bytes, arrival time in ns). Result channel: out_valid / out_stall
//   carries the verdict, the whole-byte token level and four counters.
//   One result is produced for every packet item, in order.
//   An accepted item passes the four-register chain of input register,
//   elapsed-time register, refill product register and result register;
//   throughput is one item per cycle while out_stall stays low.
//   The level update (refill, cap, compare, subtract) closes in the last
//   stage so consecutive packets see each other's level.
//   A stalled result holds; up to three more items are taken behind it
//   before in_stall rises.
//   Reset (rst_n low, synchronous) empties the pipeline, loads the
//   default fill rate and bucket size, fills the bucket and clears the
//   counters and the stored time. A cfg_we write to either register sets
//   it, fills the bucket and clears the same state; write only while idle.
// ---------------------------------------------------------------------------
`default_nettype none

module token_bucket_policer #(
  parameter int FRACTION_BITS = tbp_pkg::FRACTION_BITS_DEF,
  parameter int COUNTER_BITS  = tbp_pkg::COUNTER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbp_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tbp_pkg::LEN_W-1:0]      in_packet_length,
  input  logic [tbp_pkg::TIME_W-1:0]     in_arrival_time,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tbp_pkg::VERDICT_W-1:0]  out_verdict,
  output logic [tbp_pkg::TOKENS_W-1:0]   out_tokens_left,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_packets,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_bytes,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_packets,
  output logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_bytes
);
  import tbp_pkg::*;

  logic [CFG_W-1:0] fill_rate_r;
  logic [CFG_W-1:0] bucket_size_r;
  restart_t         restart;
  logic             el_valid;
  elapsed_item_t    el_item;
  logic             el_ready;
  logic             rf_valid;
  refill_item_t     rf_item;
  logic             rf_ready;

  always_comb begin
    restart.restart = cfg_we;
    restart.size    = (cfg_index == CFG_BUCKET_SIZE) ? cfg_wdata : bucket_size_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_rate_r   <= RATE_RESET;
      bucket_size_r <= SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_FILL_RATE) begin
        fill_rate_r <= cfg_wdata;
      end else begin
        bucket_size_r <= cfg_wdata;
      end
    end
  end

  tbp_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .restart          (restart),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_packet_length (in_packet_length),
    .in_arrival_time  (in_arrival_time),
    .item_valid       (el_valid),
    .item             (el_item),
    .item_ready       (el_ready)
  );

  tbp_refill_mul u_mul (
    .clk            (clk),
    .rst_n          (rst_n),
    .fill_rate      (fill_rate_r),
    .in_item_valid  (el_valid),
    .in_item        (el_item),
    .in_item_ready  (el_ready),
    .out_item_valid (rf_valid),
    .out_item       (rf_item),
    .out_item_ready (rf_ready)
  );

  tbp_bucket #(
    .FRACTION_BITS (FRACTION_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_bucket (
    .clk                 (clk),
    .rst_n               (rst_n),
    .restart             (restart),
    .bucket_size         (bucket_size_r),
    .in_item_valid       (rf_valid),
    .in_item             (rf_item),
    .in_item_ready       (rf_ready),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_verdict         (out_verdict),
    .out_tokens_left     (out_tokens_left),
    .out_passed_packets  (out_passed_packets),
    .out_passed_bytes    (out_passed_bytes),
    .out_dropped_packets (out_dropped_packets),
    .out_dropped_bytes   (out_dropped_bytes)
  );

endmodule

`default_nettype wire

@@ rtl/tbp_checker.sv @@
// ---------------------------------------------------------------------------
// Token bucket policer checker
// Port-level checks on the policer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "token_bucket_policer_assert.svh"

module tbp_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [tbp_pkg::LEN_W-1:0]      in_packet_length,
  input  logic [tbp_pkg::TIME_W-1:0]     in_arrival_time,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [tbp_pkg::VERDICT_W-1:0]  out_verdict,
  input  logic [tbp_pkg::TOKENS_W-1:0]   out_tokens_left,
  input  logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_packets,
  input  logic [tbp_pkg::OUT_CNT_W-1:0]  out_passed_bytes,
  input  logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_packets,
  input  logic [tbp_pkg::OUT_CNT_W-1:0]  out_dropped_bytes
);
  import tbp_pkg::*;

  logic [LEN_W+TIME_W-1:0]                    in_bus;
  logic [VERDICT_W+TOKENS_W+4*OUT_CNT_W-1:0]  result_bus;
  logic                                       item_held;
  logic                                       result_held;
  logic                                       verdict_known;

  assign in_bus        = {in_packet_length, in_arrival_time};
  assign result_bus    = {out_verdict, out_tokens_left, out_passed_packets, out_passed_bytes,
                          out_dropped_packets, out_dropped_bytes};
  assign item_held     = in_valid && in_stall;
  assign result_held   = out_valid && out_stall;
  assign verdict_known = (out_verdict == VERDICT_PASS) || (out_verdict == VERDICT_DROP) ||
                         (out_verdict == VERDICT_INVALID);

  // reset empties the pipeline
  `TBP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

  // input backs up only when every stage is full behind a stalled result
  `TBP_ASSERT(a_stall_source, in_stall |-> result_held, "input stalled without cause")

  `TBP_ASSERT(a_verdict_code, out_valid |-> verdict_known, "verdict code out of range")

  `TBP_ASSERT(a_result_hold, result_held |=> out_valid && $stable(result_bus), "result not held")

  `TBP_ASSERT(a_item_hold, item_held |=> in_valid && $stable(in_bus), "item not held")

endmodule

bind token_bucket_policer tbp_checker u_tbp_checker (.*);

`default_nettype wire
